FILE: hdl/smfe_pkg.sv
// smfe_pkg: sizes, types and saturation helpers for the schedule makespan and flowtime unit
// no dependencies; imported by smfe_accum and schedule_makespan_flowtime_eval_unit
`timescale 1ns / 1ps
`default_nettype none

package smfe_pkg;

   localparam int MAX_MACHINES = 16;
   localparam int TOTAL_WIDTH  = 32;

   localparam int MACH_W    = 5;
   localparam int TIME_W    = 16;
   localparam int CNT_W     = 5;
   localparam int OUT_W     = 32;
   localparam int IDX_W     = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
   localparam int WIDE_W    = TOTAL_WIDTH + OUT_W;
   localparam int REQ_DATA_W = ((MACH_W + TIME_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((2 * OUT_W + 7) / 8) * 8;

   localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(16);

   typedef logic [TOTAL_WIDTH-1:0] total_type;

   // one task handed from the input stage to the accumulator
   typedef struct packed {
      logic              fire;
      logic              last;
      logic [MACH_W-1:0] machine;
      logic [TIME_W-1:0] task_time;
   } task_cmd_type;

   // totals of a finished assignment
   typedef struct packed {
      logic [OUT_W-1:0] makespan;
      logic [OUT_W-1:0] flowtime;
      logic             bad;
   } score_type;

   // saturating add of a task time onto a total
   function automatic total_type sat_add(input total_type a, input logic [TIME_W-1:0] b);
      logic [TOTAL_WIDTH:0] s;
      s = {1'b0, a} + (TOTAL_WIDTH + 1)'(b);
      if (s[TOTAL_WIDTH]) begin
         return {TOTAL_WIDTH{1'b1}};
      end
      return s[TOTAL_WIDTH-1:0];
   endfunction

   // clip a total into the result field width
   function automatic logic [OUT_W-1:0] clip_out(input total_type v);
      logic [WIDE_W-1:0] w;
      w = {{OUT_W{1'b0}}, v};
      if (w > WIDE_W'({OUT_W{1'b1}})) begin
         return {OUT_W{1'b1}};
      end
      return w[OUT_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: hdl/smfe_accum.sv
// smfe_accum: per-machine busy totals, running makespan, flowtime and error flag
// depends on smfe_pkg
`timescale 1ns / 1ps
`default_nettype none

module smfe_accum (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [smfe_pkg::CNT_W-1:0] machines_in_use,
   input  wire smfe_pkg::task_cmd_type     cmd,
   output smfe_pkg::score_type             score
);
   import smfe_pkg::*;

   total_type           busy_ff [MAX_MACHINES];
   total_type           busy_in [MAX_MACHINES];
   total_type           max_ff, max_in, sum_ff, sum_in;
   logic                err_ff, err_in;

   logic                mach_ok;
   logic [IDX_W-1:0]    idx;
   total_type           new_busy;
   total_type           max_upd, sum_upd;
   logic                err_upd;

   always_comb begin
      mach_ok = (cmd.machine != '0)
             && (cmd.machine <= machines_in_use)
             && (32'(cmd.machine) <= 32'(MAX_MACHINES));
      idx      = IDX_W'(32'(cmd.machine) - 32'd1);
      new_busy = sat_add(busy_ff[idx], cmd.task_time);

      max_upd = max_ff;
      sum_upd = sum_ff;
      err_upd = err_ff;
      busy_in = busy_ff;
      if (mach_ok) begin
         busy_in[idx] = new_busy;
         if (new_busy > max_ff) begin
            max_upd = new_busy;
         end
         sum_upd = sat_add(sum_ff, cmd.task_time);
      end else begin
         err_upd = 1'b1;
      end

      score.makespan = clip_out(max_upd);
      score.flowtime = clip_out(sum_upd);
      score.bad      = err_upd;

      max_in = max_upd;
      sum_in = sum_upd;
      err_in = err_upd;
      // last task ends the assignment: start the next one from zero
      if (cmd.last) begin
         for (int i = 0; i < MAX_MACHINES; i++) begin
            busy_in[i] = '0;
         end
         max_in = '0;
         sum_in = '0;
         err_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_MACHINES; i++) begin
            busy_ff[i] <= '0;
         end
         max_ff <= '0;
         sum_ff <= '0;
         err_ff <= 1'b0;
      end else if (cmd.fire) begin
         busy_ff <= busy_in;
         max_ff  <= max_in;
         sum_ff  <= sum_in;
         err_ff  <= err_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/schedule_makespan_flowtime_eval_unit.sv
// schedule_makespan_flowtime_eval_unit: top level, input stage, result register, control register
// depends on smfe_pkg and smfe_accum
`timescale 1ns / 1ps
`default_nettype none

// scores one task-to-machine assignment, streamed one task per transfer
//  req channel: one task per transfer; req_tlast marks the final task of an assignment
//  rsp channel: one transfer per assignment carrying makespan, flowtime and the bad-machine flag
//  csr channel: writes machines_in_use; always ready, write only while the unit is idle
// timing: a task is registered in the input stage at its transfer and folded into the totals when it fires;
//  for a last task the score lands in the rsp register on that same edge and raises rsp_tvalid
// throughput: one task per cycle unless a last task waits on a stalled rsp register, set by
//  the read-add-write of one machine's busy total plus the running max compare, all combinational
// reset: all busy totals, makespan, flowtime and the flag clear; machines_in_use returns to 16
// rsp stall: a waiting score holds in the rsp register; ordinary tasks keep flowing,
//  only a last task waits in the input stage until the register frees, and
//  req_tready stays low while it waits
// machine numbers of zero, beyond the count or above 16 are ignored and raise the flag
module schedule_makespan_flowtime_eval_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // machine_number [4:0], task_time [20:5], zero pad above
   input  wire logic [smfe_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                            req_tlast,
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   // makespan [31:0], flowtime [63:32]
   output      logic [smfe_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // bad_machine_seen [0]
   output      logic [0:0]                      rsp_tuser,
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic [smfe_pkg::CNT_W-1:0]      csr_data,
   input  wire logic                            csr_valid,
   output      logic                            csr_ready
);
   import smfe_pkg::*;

   // control register
   logic [CNT_W-1:0]  count_ff;

   // input stage
   logic              s1_valid_ff, s1_valid_in;
   logic [MACH_W-1:0] s1_mach_ff;
   logic [TIME_W-1:0] s1_time_ff;
   logic              s1_last_ff;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   score_type         rsp_score_ff;

   logic              out_free;
   logic              fire;
   logic              accept;
   task_cmd_type      cmd;
   score_type         score;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_RESET;
      end else if (csr_valid && csr_ready) begin
         count_ff <= csr_data;
      end
   end

   // a last task may only fold in when its score has somewhere to go
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_tready = !s1_valid_ff || fire;
   assign accept     = req_tvalid && req_tready;

   assign s1_valid_in = accept || (s1_valid_ff && !fire);

   always_comb begin
      if (fire && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mach_ff <= req_tdata[MACH_W-1:0];
         s1_time_ff <= req_tdata[MACH_W+TIME_W-1:MACH_W];
         s1_last_ff <= req_tlast;
      end
      if (fire && s1_last_ff) begin
         rsp_score_ff <= score;
      end
   end

   always_comb begin
      cmd.fire      = fire;
      cmd.last      = s1_last_ff;
      cmd.machine   = s1_mach_ff;
      cmd.task_time = s1_time_ff;
   end

   smfe_accum u_accum (
      .clock           (clock),
      .reset           (reset),
      .machines_in_use (count_ff),
      .cmd             (cmd),
      .score           (score)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_score_ff.flowtime, rsp_score_ff.makespan});
   assign rsp_tuser  = rsp_score_ff.bad;

   // a folded last task always lands in the result register
   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      fire && s1_last_ff |=> rsp_tvalid)
      else $error("last task folded without a result");

   // a waiting last task must block new tasks while the result is stalled
   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_last_ff && rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while last task is stuck");

   // the largest machine total never exceeds the sum of all totals
   a_span_le_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_score_ff.makespan <= rsp_score_ff.flowtime)
      else $error("makespan above flowtime");

endmodule

`default_nettype wire
